@@ sv/diffusion_critical_time_step_macros.svh @@
// Assertion macros for the diffusion critical time step block.
// Expects clk and arst_n in the scope of use; no other dependencies.
`ifndef DIFFUSION_CRITICAL_TIME_STEP_MACROS_SVH
`define DIFFUSION_CRITICAL_TIME_STEP_MACROS_SVH
`ifndef NO_ASSERTIONS
`define DCTS_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("dcts assertion failed");
`define DCTS_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("dcts sequencing assertion failed");
`else
`define DCTS_ASSERT(lbl, prop)
`define DCTS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

@@ sv/dcts_pkg.sv @@
// Shared types and constants for the diffusion critical time step block.
// No dependencies; used by the controller, datapath and top level.
package dcts_pkg;
	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [16:0] SF_RESET = 17'h10000;
	localparam int unsigned ONE_Q16_SHIFT = 16;
	localparam logic [5:0] DIV_LAST = 6'd63;

	typedef enum logic [4:0] {
		OP_NONE, OP_CAPTURE, OP_READ, OP_SQ_X, OP_SQ_Y, OP_SQ_Z, OP_SQ_ACC,
		OP_CMP, OP_STORE, OP_EL_CHK, OP_MUL_RC, OP_RC_LOAD, OP_PP0, OP_PP1,
		OP_PP2, OP_PP3, OP_PP_ACC, OP_DIV_CHK, OP_DIV_STEP, OP_EL_UPD,
		OP_SC0, OP_SC1, OP_SC2, OP_EMIT
	} dcts_op_t;

	typedef struct packed {
		dcts_op_t op;
	} dcts_cmd_t;

	typedef struct packed {
		logic more_nodes;
		logic elem_end;
		logic mesh_end;
		logic el_sat;
		logic div_sat;
		logic div_last;
		logic out_free;
	} dcts_status_t;
endpackage

@@ sv/dcts_if.sv @@
// Valid/ready channel interfaces for node input and result output.
// No dependencies.
interface dcts_node_if;
	logic        valid;
	logic        ready;
	logic [31:0] node_x;
	logic [31:0] node_y;
	logic [31:0] node_z;
	logic [31:0] conductivity;
	logic [31:0] density;
	logic [31:0] specific_heat;
	logic        end_of_element;
	logic        end_of_mesh;
	modport source (output valid, node_x, node_y, node_z, conductivity, density,
		specific_heat, end_of_element, end_of_mesh, input ready);
	modport sink (input valid, node_x, node_y, node_z, conductivity, density,
		specific_heat, end_of_element, end_of_mesh, output ready);
endinterface

interface dcts_result_if;
	logic        valid;
	logic        ready;
	logic [63:0] critical_step;
	logic        step_saturated;
	modport source (output valid, critical_step, step_saturated, input ready);
	modport sink (input valid, critical_step, step_saturated, output ready);
endinterface

@@ sv/diffusion_critical_time_step.sv @@
// Node item: the new node is compared against each node stored for the element (shared multiplier), then stored.
// Element end adds the 64x64 product and 64 divide steps; saturation skips the divide steps, or both.
// Mesh end adds scaling and emit; the result sits in an output register.
// One item in flight at a time; ready is high only while the sequencer idles.
// Reset (arst_n low, asynchronous) clears counts and flags, sets minima to all ones and safety factor to one.
`include "diffusion_critical_time_step_macros.svh"
module diffusion_critical_time_step #(
	parameter int MAX_NODES  = 8,
	parameter int COORD_BITS = 32
) (
	input  logic          clk,
	input  logic          arst_n,
	dcts_node_if.sink     node,
	dcts_result_if.source result,
	input  logic          cfg_we,
	input  logic [16:0]   cfg_wdata
);
	import dcts_pkg::*;

	dcts_cmd_t    cmd;
	dcts_status_t st;
	logic         in_ready;

	// sequencer: one state per datapath operation, except S_EMIT, which issues SC2 and then EMIT
	dcts_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (node.valid),
		.in_ready (in_ready),
		.st       (st),
		.cmd      (cmd)
	);

	assign node.ready = in_ready;

	// datapath: node store, edge search, element step divide, safety scaling
	dcts_dp #(
		.MAX_NODES  (MAX_NODES),
		.COORD_BITS (COORD_BITS)
	) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.st             (st),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.node_x         (node.node_x),
		.node_y         (node.node_y),
		.node_z         (node.node_z),
		.conductivity   (node.conductivity),
		.density        (node.density),
		.specific_heat  (node.specific_heat),
		.end_of_element (node.end_of_element),
		.end_of_mesh    (node.end_of_mesh),
		.out_valid      (result.valid),
		.out_ready      (result.ready),
		.critical_step  (result.critical_step),
		.step_saturated (result.step_saturated)
	);

	// hold off new transactions until the current node is fully processed
	`DCTS_ASSERT_NEXT(a_busy_after_accept, node.valid && node.ready, !node.ready)
	// divide steps run back to back until the element update
	`DCTS_ASSERT_NEXT(a_div_seq, cmd.op == OP_DIV_STEP, cmd.op == OP_DIV_STEP || cmd.op == OP_EL_UPD)
	// a new result appears only right after an emit
	`DCTS_ASSERT(a_emit_src, $rose(result.valid) |-> $past(cmd.op == OP_EMIT))
endmodule

@@ sv/dcts_ctrl.sv @@
// Sequencing state machine for the diffusion critical time step block.
// Depends on dcts_pkg for the command and status types.
module dcts_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  dcts_pkg::dcts_status_t st,
	output dcts_pkg::dcts_cmd_t    cmd
);
	import dcts_pkg::*;

	typedef enum logic [21:0] {
		S_IDLE    = 22'd1 << 0,
		S_RD      = 22'd1 << 1,
		S_SQX     = 22'd1 << 2,
		S_SQY     = 22'd1 << 3,
		S_SQZ     = 22'd1 << 4,
		S_SQA     = 22'd1 << 5,
		S_CMP     = 22'd1 << 6,
		S_STORE   = 22'd1 << 7,
		S_EL_CHK  = 22'd1 << 8,
		S_MUL_RC  = 22'd1 << 9,
		S_RC_LOAD = 22'd1 << 10,
		S_PP0     = 22'd1 << 11,
		S_PP1     = 22'd1 << 12,
		S_PP2     = 22'd1 << 13,
		S_PP3     = 22'd1 << 14,
		S_PP_ACC  = 22'd1 << 15,
		S_DIV_CHK = 22'd1 << 16,
		S_DIV     = 22'd1 << 17,
		S_EL_UPD  = 22'd1 << 18,
		S_SC0     = 22'd1 << 19,
		S_SC1     = 22'd1 << 20,
		S_EMIT    = 22'd1 << 21
	} dcts_state_t;

	dcts_state_t state_q, state_d;
	logic        sc2_q;

	assign in_ready = (state_q == S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd.op  = OP_NONE;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.op  = OP_CAPTURE;
					state_d = S_RD;
				end
			end
			S_RD: begin
				cmd.op  = OP_READ;
				state_d = st.more_nodes ? S_SQX : S_STORE;
			end
			S_SQX: begin cmd.op = OP_SQ_X; state_d = S_SQY; end
			S_SQY: begin cmd.op = OP_SQ_Y; state_d = S_SQZ; end
			S_SQZ: begin cmd.op = OP_SQ_Z; state_d = S_SQA; end
			S_SQA: begin cmd.op = OP_SQ_ACC; state_d = S_CMP; end
			S_CMP: begin cmd.op = OP_CMP; state_d = S_RD; end
			S_STORE: begin
				cmd.op  = OP_STORE;
				state_d = st.elem_end ? S_EL_CHK : S_IDLE;
			end
			S_EL_CHK: begin
				cmd.op  = OP_EL_CHK;
				state_d = st.el_sat ? S_EL_UPD : S_MUL_RC;
			end
			S_MUL_RC: begin cmd.op = OP_MUL_RC; state_d = S_RC_LOAD; end
			S_RC_LOAD: begin cmd.op = OP_RC_LOAD; state_d = S_PP0; end
			S_PP0: begin cmd.op = OP_PP0; state_d = S_PP1; end
			S_PP1: begin cmd.op = OP_PP1; state_d = S_PP2; end
			S_PP2: begin cmd.op = OP_PP2; state_d = S_PP3; end
			S_PP3: begin cmd.op = OP_PP3; state_d = S_PP_ACC; end
			S_PP_ACC: begin cmd.op = OP_PP_ACC; state_d = S_DIV_CHK; end
			S_DIV_CHK: begin
				cmd.op  = OP_DIV_CHK;
				state_d = st.div_sat ? S_EL_UPD : S_DIV;
			end
			S_DIV: begin
				cmd.op = OP_DIV_STEP;
				if (st.div_last)
					state_d = S_EL_UPD;
			end
			S_EL_UPD: begin
				cmd.op  = OP_EL_UPD;
				state_d = st.mesh_end ? S_SC0 : S_IDLE;
			end
			S_SC0: begin cmd.op = OP_SC0; state_d = S_SC1; end
			S_SC1: begin cmd.op = OP_SC1; state_d = S_EMIT; end
			S_EMIT: begin
				// first cycle finishes the scaling sum, then wait for a free slot
				if (!sc2_q) begin
					cmd.op = OP_SC2;
				end else if (st.out_free) begin
					cmd.op  = OP_EMIT;
					state_d = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			sc2_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			sc2_q   <= (state_q == S_EMIT);
		end
	end
endmodule

@@ sv/dcts_dp.sv @@
// Datapath: node memory, shared 32x32 multiplier, divider and result register.
// Depends on dcts_pkg; driven by dcts_ctrl through the command struct.
module dcts_dp #(
	parameter int MAX_NODES  = 8,
	parameter int COORD_BITS = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  dcts_pkg::dcts_cmd_t    cmd,
	output dcts_pkg::dcts_status_t st,
	input  logic                   cfg_we,
	input  logic [16:0]            cfg_wdata,
	input  logic [31:0]            node_x,
	input  logic [31:0]            node_y,
	input  logic [31:0]            node_z,
	input  logic [31:0]            conductivity,
	input  logic [31:0]            density,
	input  logic [31:0]            specific_heat,
	input  logic                   end_of_element,
	input  logic                   end_of_mesh,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [63:0]            critical_step,
	output logic                   step_saturated
);
	import dcts_pkg::*;

	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int IW = $clog2(MAX_NODES);
	localparam int C  = COORD_BITS;

	logic [C-1:0]    px_q, py_q, pz_q;
	logic [31:0]     k_q, rho_q, c_q;
	logic            eoe_q, eom_q;
	logic [3*C-1:0]  mem [MAX_NODES];
	logic [3*C-1:0]  rd_q;
	logic [CW-1:0]   cnt_q, idx_q;
	logic [63:0]     min_edge_q, min_step_q;
	logic            sat_q;
	logic [16:0]     sf_q;
	logic [31:0]     mul_a, mul_b;
	logic [63:0]     mul_q, rc_q;
	logic [65:0]     acc_q;
	logic            big_q;
	logic [127:0]    prod_q;
	logic [32:0]     rem_q;
	logic [5:0]      bit_q;
	logic            ovalid_q, osat_q;
	logic [63:0]     ocrit_q;

	logic [C-1:0]    cp, cq;
	logic [C:0]      diff, abs_u;
	logic [32:0]     ad;
	logic [63:0]     edge_sq;
	logic            edge_bad;
	logic [32:0]     dvs;
	logic [33:0]     trial, trial_sub;
	logic            trial_ge;
	logic            store_ok;

	assign store_ok = (cnt_q < CW'(MAX_NODES));

	// coordinate difference for the current square
	always_comb begin
		cp = px_q;
		cq = rd_q[C-1:0];
		case (cmd.op)
			OP_SQ_Y: begin cp = py_q; cq = rd_q[2*C-1:C]; end
			OP_SQ_Z: begin cp = pz_q; cq = rd_q[3*C-1:2*C]; end
			default: begin cp = px_q; cq = rd_q[C-1:0]; end
		endcase
		diff  = {cp[C-1], cp} - {cq[C-1], cq};
		abs_u = diff[C] ? (~diff + 1'b1) : diff;
		ad    = 33'(abs_u);
	end

	assign edge_bad = big_q || (acc_q[65:64] != 2'b00);
	assign edge_sq  = edge_bad ? ALL_ONES : acc_q[63:0];

	assign dvs       = {k_q, 1'b0};
	assign trial     = {rem_q, prod_q[63]};
	assign trial_sub = trial - {1'b0, dvs};
	assign trial_ge  = (trial >= {1'b0, dvs});

	// shared multiplier operand select
	always_comb begin
		mul_a = 32'd0;
		mul_b = 32'd0;
		case (cmd.op) inside
			OP_SQ_X, OP_SQ_Y, OP_SQ_Z: begin mul_a = ad[31:0]; mul_b = ad[31:0]; end
			OP_MUL_RC: begin mul_a = rho_q; mul_b = c_q; end
			OP_PP0: begin mul_a = min_edge_q[31:0]; mul_b = rc_q[31:0]; end
			OP_PP1: begin mul_a = min_edge_q[31:0]; mul_b = rc_q[63:32]; end
			OP_PP2: begin mul_a = min_edge_q[63:32]; mul_b = rc_q[31:0]; end
			OP_PP3: begin mul_a = min_edge_q[63:32]; mul_b = rc_q[63:32]; end
			OP_SC0: begin mul_a = min_step_q[31:0]; mul_b = {15'd0, sf_q}; end
			OP_SC1: begin mul_a = min_step_q[63:32]; mul_b = {15'd0, sf_q}; end
			default: begin mul_a = 32'd0; mul_b = 32'd0; end
		endcase
	end

	always_ff @(posedge clk) begin
		mul_q <= {32'd0, mul_a} * {32'd0, mul_b};
	end

	// node memory, one write and one registered read
	always_ff @(posedge clk) begin
		if (cmd.op == OP_STORE && store_ok)
			mem[cnt_q[IW-1:0]] <= {pz_q, py_q, px_q};
		if (cmd.op == OP_READ && st.more_nodes)
			rd_q <= mem[idx_q[IW-1:0]];
	end

	// payload registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_CAPTURE: begin
				px_q  <= node_x[C-1:0];
				py_q  <= node_y[C-1:0];
				pz_q  <= node_z[C-1:0];
				k_q   <= conductivity;
				rho_q <= density;
				c_q   <= specific_heat;
				eoe_q <= end_of_element;
				eom_q <= end_of_mesh;
			end
			OP_SQ_X: begin big_q <= ad[32]; acc_q <= 66'd0; end
			OP_SQ_Y: begin big_q <= big_q | ad[32]; acc_q <= 66'(mul_q); end
			OP_SQ_Z: begin big_q <= big_q | ad[32]; acc_q <= acc_q + 66'(mul_q); end
			OP_SQ_ACC: acc_q <= acc_q + 66'(mul_q);
			OP_EL_CHK: if (st.el_sat) prod_q[63:0] <= ALL_ONES;
			OP_RC_LOAD: rc_q <= mul_q;
			OP_PP1: prod_q <= 128'(mul_q);
			OP_PP2: prod_q <= prod_q + (128'(mul_q) << 32);
			OP_PP3: prod_q <= prod_q + (128'(mul_q) << 32);
			OP_PP_ACC: prod_q <= prod_q + (128'(mul_q) << 64);
			OP_DIV_CHK: begin
				if (st.div_sat)
					prod_q[63:0] <= ALL_ONES;
				else
					rem_q <= prod_q[96:64];
			end
			OP_DIV_STEP: begin
				rem_q        <= trial_ge ? trial_sub[32:0] : trial[32:0];
				prod_q[63:0] <= {prod_q[62:0], trial_ge};
			end
			OP_SC1: prod_q <= 128'(mul_q);
			OP_SC2: prod_q <= prod_q + (128'(mul_q) << 32);
			default: ;
		endcase
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q      <= '0;
			idx_q      <= '0;
			min_edge_q <= ALL_ONES;
			min_step_q <= ALL_ONES;
			sat_q      <= 1'b0;
			sf_q       <= SF_RESET;
			bit_q      <= '0;
			ovalid_q   <= 1'b0;
			ocrit_q    <= '0;
			osat_q     <= 1'b0;
		end else begin
			if (cfg_we)
				sf_q <= cfg_wdata;
			// drop the result once taken, unless a new one is loaded this cycle
			if (ovalid_q && out_ready && cmd.op != OP_EMIT)
				ovalid_q <= 1'b0;
			case (cmd.op)
				OP_CAPTURE: idx_q <= '0;
				OP_CMP: begin
					if (edge_bad)
						sat_q <= 1'b1;
					if (edge_sq < min_edge_q)
						min_edge_q <= edge_sq;
					idx_q <= idx_q + 1'b1;
				end
				OP_STORE: if (store_ok) cnt_q <= cnt_q + 1'b1;
				OP_EL_CHK: if (st.el_sat) sat_q <= 1'b1;
				OP_DIV_CHK: begin
					if (st.div_sat)
						sat_q <= 1'b1;
					bit_q <= '0;
				end
				OP_DIV_STEP: bit_q <= bit_q + 1'b1;
				OP_EL_UPD: begin
					if (prod_q[63:0] < min_step_q)
						min_step_q <= prod_q[63:0];
					min_edge_q <= ALL_ONES;
					cnt_q      <= '0;
				end
				OP_EMIT: begin
					if (min_step_q == ALL_ONES || prod_q[80]) begin
						ocrit_q <= ALL_ONES;
						osat_q  <= 1'b1;
					end else begin
						ocrit_q <= prod_q[ONE_Q16_SHIFT +: 64];
						osat_q  <= sat_q;
					end
					ovalid_q   <= 1'b1;
					cnt_q      <= '0;
					min_edge_q <= ALL_ONES;
					min_step_q <= ALL_ONES;
					sat_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

	assign st.more_nodes = (idx_q < cnt_q);
	assign st.elem_end   = eoe_q | eom_q;
	assign st.mesh_end   = eom_q;
	assign st.el_sat     = (min_edge_q == ALL_ONES) || (k_q == 32'd0);
	assign st.div_sat    = (prod_q[127:64] >= {31'd0, dvs});
	assign st.div_last   = (bit_q == DIV_LAST);
	assign st.out_free   = !ovalid_q || out_ready;

	assign out_valid      = ovalid_q;
	assign critical_step  = ocrit_q;
	assign step_saturated = osat_q;
endmodule
